// ----- src/rrda_pkg.sv -----
`default_nettype none
package rrda_pkg;

	localparam int PID_W = 6;

	// event codes
	localparam logic [2:0] F_CREATE  = 3'd0;
	localparam logic [2:0] F_EXIT    = 3'd1;
	localparam logic [2:0] F_BLOCK   = 3'd2;
	localparam logic [2:0] F_UNBLOCK = 3'd3;
	localparam logic [2:0] F_SLICE   = 3'd4;
	localparam logic [2:0] F_READ    = 3'd5;

	// process states
	localparam logic [2:0] ST_FREE  = 3'd0;
	localparam logic [2:0] ST_RUN   = 3'd1;
	localparam logic [2:0] ST_READY = 3'd2;
	localparam logic [2:0] ST_BLOCK = 3'd3;
	localparam logic [2:0] ST_EXIT  = 3'd4;

	// result status
	localparam logic [1:0] STS_OK     = 2'd0;
	localparam logic [1:0] STS_STATE  = 2'd1;
	localparam logic [1:0] STS_BADPID = 2'd2;

	typedef struct packed {
		logic [2:0]       func;
		logic [31:0]      event_time;
		logic [PID_W-1:0] process_id;
	} req_word_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [PID_W-1:0] running_pid;
		logic [6:0]       ready_count;
		logic [2:0]       proc_state;
		logic [31:0]      run_total;
		logic [31:0]      ready_total;
		logic [31:0]      blocked_total;
		logic [31:0]      idle_total;
	} rsp_word_t;

	// queue cell control, broadcast to every cell
	typedef struct packed {
		logic             rm_en;
		logic [PID_W-1:0] rm_pid;
		logic [PID_W-1:0] load_pid;
	} q_ctl_t;

endpackage
`default_nettype wire

// ----- src/rrda_ram.sv -----
`default_nettype none
module rrda_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] wa,
	input  wire logic [WIDTH-1:0]         wd,
	input  wire logic [$clog2(DEPTH)-1:0] ra,
	output logic      [WIDTH-1:0]         rd
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wa] <= wd;
		end
		rd <= mem[ra];
	end
endmodule
`default_nettype wire

// ----- src/rrda_cell.sv -----
`default_nettype none
module rrda_cell import rrda_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire q_ctl_t           ctl,
	input  wire logic             load,
	input  wire logic             hole_in,
	output logic                  hole_out,
	input  wire logic [PID_W-1:0] nxt_pid,
	output logic      [PID_W-1:0] pid
);
	// a hole opens at the matching cell and every later cell pulls from its neighbor
	assign hole_out = hole_in | (ctl.rm_en & (pid == ctl.rm_pid));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pid <= '0;
		end else if (load) begin
			pid <= ctl.load_pid;
		end else if (hole_out) begin
			pid <= nxt_pid;
		end
	end
endmodule
`default_nettype wire

// ----- src/round_robin_dispatch_accounting.sv -----
// Round-robin dispatcher with per-process time accounting.
// Each accepted word runs a process table read/modify/write once for the addressed
// process, once for the new head when one is promoted, and a last re-read of the addressed
// process for its totals; a new word is taken only back in idle, after any result stall.
// Reset: arst_n asynchronous, clears the queue, the totals' valid bits and idle time.
`default_nettype none
module round_robin_dispatch_accounting import rrda_pkg::*; #(
	parameter int MAX_PROCS = 64,
	parameter int TIME_BITS = 32
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      req_valid,
	output logic           req_ready,
	input  wire req_word_t req,
	output logic           rsp_valid,
	input  wire logic      rsp_ready,
	output rsp_word_t      rsp
);
	localparam int AW    = (MAX_PROCS > 2) ? $clog2(MAX_PROCS) : 1;
	localparam int DEPTH = 1 << AW;
	localparam int CW    = $clog2(MAX_PROCS + 1);
	localparam int TB    = TIME_BITS;
	localparam int RW    = 3 + 4 * TB;

	// sequencer codes
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_RDP  = 3'd1; // read addressed process (or head on slice)
	localparam logic [2:0] S_EVP  = 3'd2; // apply event, update queue
	localparam logic [2:0] S_RDH  = 3'd3; // read newly promoted head
	localparam logic [2:0] S_EVH  = 3'd4; // book head's ready time, mark running
	localparam logic [2:0] S_RDF  = 3'd5; // re-read addressed process for totals
	localparam logic [2:0] S_FIN  = 3'd6; // load result word

	logic [2:0]       state_q, state_nx;
	logic [2:0]       func_q;
	logic [TB-1:0]    t_q;
	logic [PID_W-1:0] pid_q;
	logic [1:0]       status_q, status_nx;
	logic [CW-1:0]    count_q, count_nx;
	logic [TB-1:0]    idle_since_q, idle_since_nx;
	logic [TB-1:0]    idle_acc_q, idle_acc_nx;

	// ---------------- process table: {state, entry, run, ready, blocked}
	logic          ram_we;
	logic [AW-1:0] ram_wa, ram_ra;
	logic [RW-1:0] ram_wd, ram_rd;
	logic [DEPTH-1:0] vld_q;  // entry written since reset; unwritten reads as free/zero
	logic          rd_vld_q;

	rrda_ram #(.WIDTH(RW), .DEPTH(DEPTH)) u_tab (
		.clk(clk), .we(ram_we), .wa(ram_wa), .wd(ram_wd), .ra(ram_ra), .rd(ram_rd)
	);

	logic [2:0]    r_st;
	logic [TB-1:0] r_en, r_run, r_rdy, r_blk, d_t;
	assign r_st  = rd_vld_q ? ram_rd[4*TB +: 3] : ST_FREE;
	assign r_en  = rd_vld_q ? ram_rd[3*TB +: TB] : '0;
	assign r_run = rd_vld_q ? ram_rd[2*TB +: TB] : '0;
	assign r_rdy = rd_vld_q ? ram_rd[TB +: TB]   : '0;
	assign r_blk = rd_vld_q ? ram_rd[0 +: TB]    : '0;
	assign d_t   = t_q - r_en;

	// ---------------- ready queue: a row of cells, cell 0 is the running process
	q_ctl_t           q_ctl;
	logic             q_load;
	logic [CW-1:0]    q_tail;
	logic [MAX_PROCS:0] hole;
	logic [PID_W-1:0] cell_pid [MAX_PROCS];

	assign hole[0] = 1'b0;

	for (genvar i = 0; i < MAX_PROCS; i++) begin : g_cell
		logic [PID_W-1:0] nxt;
		if (i == MAX_PROCS - 1) begin : g_last
			assign nxt = cell_pid[i];
		end else begin : g_mid
			assign nxt = cell_pid[i+1];
		end
		rrda_cell u_cell (
			.clk(clk), .arst_n(arst_n), .ctl(q_ctl),
			.load(q_load && (q_tail == CW'(i))),
			.hole_in(hole[i]), .hole_out(hole[i+1]),
			.nxt_pid(nxt), .pid(cell_pid[i])
		);
	end

	logic [AW-1:0] p_idx, h_idx;
	logic          pid_ok;
	assign p_idx  = AW'(pid_q);
	assign h_idx  = AW'(cell_pid[0]);
	assign pid_ok = (pid_q != '0) && (32'(pid_q) < MAX_PROCS);

	assign req_ready = (state_q == S_IDLE);

	always_comb begin
		ram_ra = p_idx;
		if (state_q == S_RDH || (state_q == S_RDP && func_q == F_SLICE)) begin
			ram_ra = h_idx;
		end
	end

	// ---------------- event decision
	logic [2:0]    w_st;
	logic [TB-1:0] w_en, w_run, w_rdy, w_blk;

	always_comb begin
		state_nx      = state_q;
		status_nx     = status_q;
		count_nx      = count_q;
		idle_since_nx = idle_since_q;
		idle_acc_nx   = idle_acc_q;
		ram_we        = 1'b0;
		ram_wa        = p_idx;
		w_st          = r_st;
		w_en          = t_q;
		w_run         = r_run;
		w_rdy         = r_rdy;
		w_blk         = r_blk;
		q_ctl.rm_en   = 1'b0;
		q_ctl.rm_pid  = pid_q;
		q_ctl.load_pid = pid_q;
		q_load        = 1'b0;
		q_tail        = count_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					state_nx = S_RDP;
				end
			end
			S_RDP: state_nx = S_EVP;
			S_EVP: begin
				state_nx  = S_RDF;
				status_nx = STS_OK;
				if (func_q <= F_UNBLOCK && !pid_ok) begin
					status_nx = STS_BADPID;
				end else if (func_q == F_READ && 32'(pid_q) >= MAX_PROCS) begin
					status_nx = STS_BADPID;
				end else if (func_q == F_CREATE || func_q == F_UNBLOCK) begin
					if ((func_q == F_CREATE && r_st != ST_FREE) ||
					    (func_q == F_UNBLOCK && r_st != ST_BLOCK)) begin
						status_nx = STS_STATE;
					end else begin
						if (func_q == F_UNBLOCK) begin
							w_blk = r_blk + d_t;
						end
						q_load   = 1'b1;
						count_nx = count_q + 1'b1;
						if (count_q == '0) begin
							idle_acc_nx = idle_acc_q + (t_q - idle_since_q);
							w_st = ST_RUN;
						end else begin
							w_st = ST_READY;
						end
						ram_we = 1'b1;
					end
				end else if (func_q == F_EXIT || func_q == F_BLOCK) begin
					w_st = (func_q == F_EXIT) ? ST_EXIT : ST_BLOCK;
					if (r_st == ST_RUN) begin
						w_run       = r_run + d_t;
						q_ctl.rm_en = 1'b1;
						count_nx    = count_q - 1'b1;
						ram_we      = 1'b1;
						if (count_q > CW'(1)) begin
							state_nx = S_RDH;
						end else begin
							idle_since_nx = t_q;
						end
					end else if (r_st == ST_READY) begin
						w_rdy       = r_rdy + d_t;
						q_ctl.rm_en = 1'b1;
						count_nx    = count_q - 1'b1;
						ram_we      = 1'b1;
					end else if (r_st == ST_BLOCK && func_q == F_EXIT) begin
						w_blk  = r_blk + d_t;
						ram_we = 1'b1;
					end else begin
						status_nx = STS_STATE;
					end
				end else if (func_q == F_SLICE) begin
					// rotate when more than one is queued: head leaves cell 0 and reloads at the tail
					if (count_q > CW'(1)) begin
						ram_wa         = h_idx;
						w_run          = r_run + d_t;
						w_st           = ST_READY;
						q_ctl.rm_en    = 1'b1;
						q_ctl.rm_pid   = cell_pid[0];
						q_ctl.load_pid = cell_pid[0];
						q_load         = 1'b1;
						q_tail         = count_q - 1'b1;
						ram_we         = 1'b1;
						state_nx       = S_RDH;
					end
				end else if (func_q != F_READ) begin
					status_nx = STS_STATE;
				end
			end
			S_RDH: state_nx = S_EVH;
			S_EVH: begin
				ram_we   = 1'b1;
				ram_wa   = h_idx;
				w_st     = ST_RUN;
				w_rdy    = r_rdy + d_t;
				state_nx = S_RDF;
			end
			S_RDF: state_nx = S_FIN;
			S_FIN: begin
				if (!rsp_valid || rsp_ready) begin
					state_nx = S_IDLE;
				end
			end
			default: state_nx = S_IDLE;
		endcase
		ram_wd = {w_st, w_en, w_run, w_rdy, w_blk};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			status_q     <= STS_OK;
			count_q      <= '0;
			idle_since_q <= '0;
			idle_acc_q   <= '0;
			vld_q        <= '0;
			rsp_valid    <= 1'b0;
		end else begin
			state_q      <= state_nx;
			status_q     <= status_nx;
			count_q      <= count_nx;
			idle_since_q <= idle_since_nx;
			idle_acc_q   <= idle_acc_nx;
			if (ram_we) begin
				vld_q[ram_wa] <= 1'b1;
			end
			if (state_q == S_FIN && (!rsp_valid || rsp_ready)) begin
				rsp_valid <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		rd_vld_q <= vld_q[ram_ra];
		if (req_valid && req_ready) begin
			func_q <= req.func;
			t_q    <= TB'(req.event_time);
			pid_q  <= req.process_id;
		end
		if (state_q == S_FIN && (!rsp_valid || rsp_ready)) begin
			rsp.status      <= status_q;
			rsp.running_pid <= (count_q != '0) ? cell_pid[0] : '0;
			rsp.ready_count <= 7'(count_q);
			rsp.idle_total  <= 32'(idle_acc_q);
			if (pid_ok && status_q != STS_BADPID) begin
				rsp.proc_state    <= r_st;
				rsp.run_total     <= 32'(r_run);
				rsp.ready_total   <= 32'(r_rdy);
				rsp.blocked_total <= 32'(r_blk);
			end else begin
				rsp.proc_state    <= ST_FREE;
				rsp.run_total     <= '0;
				rsp.ready_total   <= '0;
				rsp.blocked_total <= '0;
			end
		end
	end

	// ---------------- checks
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(count_q) <= MAX_PROCS)
		else $error("ready queue overflow");

	a_idle_head: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.ready_count == '0 |-> rsp.running_pid == '0)
		else $error("running pid while queue empty");

	a_we_state: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (state_q == S_EVP || state_q == S_EVH))
		else $error("table write outside update step");

	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> state_q == S_RDP)
		else $error("accepted word did not start a read");
endmodule
`default_nettype wire
